// ===== rtl/core/prf_pkg.sv =====
package prf_pkg;

    localparam int unsigned PRF_WIDTH       = 16;
    localparam int unsigned PRF_MAX_FACTORS = 8;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_FCHK,
        S_FDIV,
        S_FREM,
        S_CAND,
        S_EXPD,
        S_PSTEP,
        S_PMUL,
        S_PRED,
        S_DONE
    } t_state;

    // Divider operation selection
    typedef enum logic [1:0] {
        D_FACT,
        D_EXPO,
        D_MOD
    } t_dop;

endpackage

// ===== rtl/core/primitive_root_finder_unit.sv =====
// Smallest primitive root search. Raise start with i_modulus while busy is low;
// one result comes back with a one-cycle o_valid strobe and cannot be stalled,
// so the receiver must take it in that cycle. A shared bit-serial divider does all
// trial divisions, exponent splits and modular reductions; a modular power costs
// one reduction per exponent bit and one more for each set bit. The time per item
// depends on the factor scan of n-1 and on how many candidates are rejected.
// Moduli below three go straight to the done state and return found low.
module primitive_root_finder_unit #(
    parameter int unsigned WIDTH       = prf_pkg::PRF_WIDTH,
    parameter int unsigned MAX_FACTORS = prf_pkg::PRF_MAX_FACTORS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_modulus,
    output logic        o_valid,
    output logic [15:0] o_root,
    output logic        o_found
);
    import prf_pkg::*;

    localparam int unsigned FW = $clog2(MAX_FACTORS + 1);
    localparam int unsigned IW = (MAX_FACTORS > 1) ? $clog2(MAX_FACTORS) : 1;

    t_state r_state, n_state;

    logic [WIDTH-1:0] r_n, r_s, r_val, r_k, r_m, r_e, r_acc, r_sq;
    logic [WIDTH-1:0] r_primes [MAX_FACTORS];
    logic [FW-1:0]    r_cnt;
    logic [FW-1:0]    r_idx;
    logic             r_mulsel;  // 0: acc*sq, 1: sq*sq
    logic             r_valid, r_found;
    logic [WIDTH-1:0] r_root;
    logic             r_dstart;
    logic [2*WIDTH-1:0] r_num;
    logic [WIDTH-1:0]   r_den;

    logic               w_ddone;
    logic [2*WIDTH-1:0] w_quot;
    logic [WIDTH-1:0]   w_rem;
    logic [WIDTH-1:0]   w_in_n;
    logic [2*WIDTH-1:0] w_kk;
    logic [IW-1:0]      w_pi;

    assign w_in_n = WIDTH'(i_modulus);
    assign w_kk   = r_k * r_k;
    assign w_pi   = r_idx[IW-1:0];

    prf_divu #(.W(WIDTH)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_dstart),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (w_ddone),
        .o_quot  (w_quot),
        .o_rem   (w_rem)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (start) n_state = (w_in_n >= WIDTH'(3)) ? S_FCHK : S_DONE;
            S_FCHK:  begin
                if (r_val <= WIDTH'(1))                     n_state = S_CAND;
                else if (w_kk > {{WIDTH{1'b0}}, r_val})     n_state = S_CAND;
                else                                        n_state = S_FDIV;
            end
            S_FDIV:  if (w_ddone) n_state = (w_rem == '0) ? S_FREM : S_FCHK;
            S_FREM:  if (w_ddone && w_rem != '0) n_state = S_FCHK;
            S_CAND:  begin
                if (r_m >= r_n)          n_state = S_DONE;
                else if (r_idx >= r_cnt) n_state = S_DONE;
                else                     n_state = S_EXPD;
            end
            S_EXPD:  if (w_ddone) n_state = S_PSTEP;
            S_PSTEP: n_state = (r_e == '0) ? S_CAND : S_PMUL;
            S_PMUL:  n_state = S_PRED;
            S_PRED:  if (w_ddone) n_state = r_mulsel ? S_PSTEP : S_PMUL;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and sequencing registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= 1'b0;
            r_dstart <= 1'b0;
            r_cnt    <= '0;
            r_idx    <= '0;
        end else begin
            r_state  <= n_state;
            r_valid  <= 1'b0;
            r_dstart <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    r_n   <= w_in_n;
                    r_s   <= w_in_n - 1'b1;
                    r_val <= w_in_n - 1'b1;
                    r_k   <= WIDTH'(2);
                    r_m   <= WIDTH'(2);
                    r_cnt <= '0;
                    r_idx <= '0;
                    r_found <= 1'b0;
                    r_root  <= '0;
                end
                S_FCHK: begin
                    if (r_val > WIDTH'(1)) begin
                        if (w_kk > {{WIDTH{1'b0}}, r_val}) begin
                            if (r_cnt < FW'(MAX_FACTORS)) begin
                                r_primes[r_cnt[IW-1:0]] <= r_val;
                                r_cnt <= r_cnt + 1'b1;
                            end
                        end else begin
                            r_num    <= {{WIDTH{1'b0}}, r_val};
                            r_den    <= r_k;
                            r_dstart <= 1'b1;
                        end
                    end
                end
                S_FDIV: if (w_ddone) begin
                    if (w_rem == '0) begin
                        if (r_cnt < FW'(MAX_FACTORS)) begin
                            r_primes[r_cnt[IW-1:0]] <= r_k;
                            r_cnt <= r_cnt + 1'b1;
                        end
                        r_val    <= w_quot[WIDTH-1:0];
                        r_num    <= w_quot;
                        r_dstart <= 1'b1;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_FREM: if (w_ddone) begin
                    if (w_rem == '0) begin
                        r_val    <= w_quot[WIDTH-1:0];
                        r_num    <= w_quot;
                        r_dstart <= 1'b1;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_CAND: begin
                    if (r_m < r_n) begin
                        if (r_idx >= r_cnt) begin
                            r_root  <= r_m;
                            r_found <= 1'b1;
                        end else begin
                            r_num    <= {{WIDTH{1'b0}}, r_s};
                            r_den    <= r_primes[w_pi];
                            r_dstart <= 1'b1;
                        end
                    end
                end
                S_EXPD: if (w_ddone) begin
                    r_e   <= w_quot[WIDTH-1:0];
                    r_acc <= WIDTH'(1);
                    r_sq  <= r_m;
                    r_den <= r_n;
                end
                S_PSTEP: begin
                    if (r_e == '0) begin
                        // acc==1 fails this candidate, else try next prime
                        if (r_acc == WIDTH'(1)) begin
                            r_m   <= r_m + 1'b1;
                            r_idx <= '0;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                    r_mulsel <= ~r_e[0];
                end
                S_PMUL: begin
                    r_num    <= r_mulsel ? (r_sq * r_sq) : (r_acc * r_sq);
                    r_dstart <= 1'b1;
                end
                S_PRED: if (w_ddone) begin
                    if (r_mulsel) begin
                        r_sq <= w_rem;
                        r_e  <= r_e >> 1;
                    end else begin
                        r_acc    <= w_rem;
                        r_mulsel <= 1'b1;
                    end
                end
                S_DONE: r_valid <= 1'b1;
                default: ;
            endcase
        end
    end

    // Outputs
    always_comb begin
        busy    = (r_state != S_IDLE);
        o_valid = r_valid;
        o_root  = 16'(r_root);
        o_found = r_found;
    end

endmodule

// ===== rtl/core/prf_divu.sv =====
// Restoring divider, one quotient bit per cycle.
module prf_divu #(
    parameter int unsigned W = prf_pkg::PRF_WIDTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [2*W-1:0] i_num,
    input  logic [W-1:0]   i_den,
    output logic           o_done,
    output logic [2*W-1:0] o_quot,
    output logic [W-1:0]   o_rem
);
    import prf_pkg::*;

    localparam int unsigned CW = $clog2(2*W + 1);

    logic [2*W-1:0] r_quot;
    logic [W:0]     r_rem;
    logic [W-1:0]   r_den;
    logic [CW-1:0]  r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [W:0]     w_sh;
    logic [W:0]     w_diff;

    assign w_sh   = {r_rem[W-1:0], r_quot[2*W-1]};
    assign w_diff = w_sh - {1'b0, r_den};

    // Shift in one numerator bit, subtract if it fits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(2*W);
                r_quot <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (!w_diff[W]) begin
                    r_rem  <= w_diff;
                    r_quot <= {r_quot[2*W-2:0], 1'b1};
                end else begin
                    r_rem  <= w_sh;
                    r_quot <= {r_quot[2*W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem[W-1:0];

endmodule

// ===== verif/tb_primitive_root_finder_unit.sv =====
`timescale 1ns / 100ps

module tb_primitive_root_finder_unit;

    localparam int unsigned W        = prf_pkg::PRF_WIDTH;
    localparam int unsigned NFACT    = prf_pkg::PRF_MAX_FACTORS;
    localparam int unsigned N_RANDOM = 100;
    localparam int unsigned IDLE_MAX = 4000000;
    localparam int unsigned TAIL     = 200;

    // Directed: below three, tiny primes and composites, field extremes
    localparam logic [15:0] DIRECTED [17] = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5,
                                               16'd7, 16'd9, 16'd23, 16'd41, 16'd257,
                                               16'd561, 16'd4099, 16'd32768, 16'd65521,
                                               16'd65534, 16'd65535};

    typedef struct packed {
        logic [15:0] root;
        logic        found;
    } t_root_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [15:0] i_modulus;
    logic        o_valid;
    logic [15:0] o_root;
    logic        o_found;

    logic [15:0] pending_moduli[$];
    t_root_res   expected_roots[$];
    logic        took;
    int unsigned gap_left;
    int unsigned idle_cycles;
    int unsigned errors = 0;

    primitive_root_finder_unit DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_modulus (i_modulus),
        .o_valid   (o_valid),
        .o_root    (o_root),
        .o_found   (o_found)
    );

    // Generate clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Raise base to expo modulo modv by square-and-multiply
    function automatic longint unsigned pow_mod(longint unsigned base, longint unsigned expo,
                                                longint unsigned modv);
        longint unsigned acc;
        longint unsigned sq;
        acc = 1 % modv;
        sq  = base % modv;
        while (expo > 0) begin
            if (expo[0])
                acc = (acc * sq) % modv;
            expo = expo >> 1;
            sq = (sq * sq) % modv;
        end
        return acc;
    endfunction

    // Compute smallest candidate that fails no prime-power test
    function automatic t_root_res search_root(logic [15:0] modulus);
        longint unsigned n;
        longint unsigned s;
        longint unsigned v;
        longint unsigned k;
        longint unsigned m;
        longint unsigned primes[NFACT];
        int              count;
        bit              ok;
        t_root_res       res;
        n = modulus & ((64'd1 << W) - 1);
        res.root  = '0;
        res.found = 1'b0;
        count = 0;
        if (n >= 3) begin
            s = n - 1;
            v = s;
            k = 2;
            // Collect distinct primes of n-1 by trial division
            while (v > 1) begin
                if (k * k > v) begin
                    if (count < NFACT) begin
                        primes[count] = v;
                        count++;
                    end
                    break;
                end
                if (v % k == 0) begin
                    if (count < NFACT) begin
                        primes[count] = k;
                        count++;
                    end
                    while (v % k == 0)
                        v = v / k;
                end
                k++;
            end
            for (m = 2; m < n; m++) begin
                ok = 1'b1;
                for (int i = 0; i < count; i++) begin
                    if (pow_mod(m, s / primes[i], n) == 1) begin
                        ok = 1'b0;
                        break;
                    end
                end
                if (ok) begin
                    res.root  = m[15:0];
                    res.found = 1'b1;
                    break;
                end
            end
        end
        return res;
    endfunction

    function automatic bit is_prime(int unsigned v);
        if (v < 2)
            return 1'b0;
        for (int unsigned d = 2; d * d <= v; d++) begin
            if (v % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Drive transfers at the falling edge, one assignment per signal
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start     <= 1'b0;
            i_modulus <= '0;
            gap_left  = 0;
        end else begin
            if (took) begin
                void'(pending_moduli.pop_front());
                gap_left = $urandom_range(0, 7);
            end
            if (start && !took) begin
                // hold the offered item until it is taken
            end else if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (pending_moduli.size() > 0) begin
                start     <= 1'b1;
                i_modulus <= pending_moduli[0];
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Sample transfers, check results and watch for a hang
    always @(posedge i_clk) begin
        t_root_res want;
        if (!i_rst_n) begin
            took        <= 1'b0;
            idle_cycles <= 0;
        end else begin
            took <= start && !busy;
            if (start && !busy)
                expected_roots = {expected_roots, search_root(i_modulus)};
            if (o_valid) begin
                if (expected_roots.size() == 0) begin
                    $error("unexpected result root=%0d found=%0d", o_root, o_found);
                    errors++;
                end else begin
                    want = expected_roots.pop_front();
                    if (o_root !== want.root) begin
                        $error("root: expected %0d actual %0d", want.root, o_root);
                        errors++;
                    end
                    if (o_found !== want.found) begin
                        $error("found: expected %0d actual %0d", want.found, o_found);
                        errors++;
                    end
                end
            end
            if ((start && !busy) || o_valid) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_MAX) begin
                $display("primitive_root_finder_unit: mismatch");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        int unsigned v;
        i_rst_n   = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (DIRECTED[i])
            pending_moduli = {pending_moduli, DIRECTED[i]};

        // Random: mostly primes of any size, the rest arbitrary values
        for (int i = 0; i < N_RANDOM; i++) begin
            if ($urandom_range(0, 9) < 7) begin
                do
                    v = $urandom_range(3, 65535);
                while (!is_prime(v));
            end else begin
                v = $urandom_range(0, 65535);
            end
            pending_moduli = {pending_moduli, v[15:0]};
        end

        wait (pending_moduli.size() == 0);
        wait (expected_roots.size() == 0);
        repeat (TAIL) @(posedge i_clk);
        if (errors == 0)
            $display("primitive_root_finder_unit: match");
        else
            $display("primitive_root_finder_unit: mismatch");
        $finish;
    end

endmodule
